FILE: sv/ppcx_pkg.sv
// Shared types and codes for the PowerPC integer execute unit.
// No dependencies; used by ppcx_alu, powerpc_integer_execute_unit and tb.
package ppcx_pkg;

    localparam int XLEN = 32;
    localparam int NREG = 32;
    localparam int RIDX = 5;

    // Command codes
    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Primary opcodes
    localparam logic [5:0] OP_MULLI  = 6'd7;
    localparam logic [5:0] OP_CMPLI  = 6'd10;
    localparam logic [5:0] OP_CMPI   = 6'd11;
    localparam logic [5:0] OP_ADDIC  = 6'd12;
    localparam logic [5:0] OP_ADDICR = 6'd13;
    localparam logic [5:0] OP_ADDI   = 6'd14;
    localparam logic [5:0] OP_ADDIS  = 6'd15;
    localparam logic [5:0] OP_RLWIMI = 6'd20;
    localparam logic [5:0] OP_RLWINM = 6'd21;
    localparam logic [5:0] OP_ORI    = 6'd24;
    localparam logic [5:0] OP_ORIS   = 6'd25;
    localparam logic [5:0] OP_XORI   = 6'd26;
    localparam logic [5:0] OP_XORIS  = 6'd27;
    localparam logic [5:0] OP_ANDI   = 6'd28;
    localparam logic [5:0] OP_ANDIS  = 6'd29;
    localparam logic [5:0] OP_EXT    = 6'd31;

    // Extended opcodes (10-bit)
    localparam logic [9:0] XO_CMP    = 10'd0;
    localparam logic [9:0] XO_CMPL   = 10'd32;
    localparam logic [9:0] XO_AND    = 10'd28;
    localparam logic [9:0] XO_ANDC   = 10'd60;
    localparam logic [9:0] XO_NOR    = 10'd124;
    localparam logic [9:0] XO_EQV    = 10'd284;
    localparam logic [9:0] XO_XOR    = 10'd316;
    localparam logic [9:0] XO_ORC    = 10'd412;
    localparam logic [9:0] XO_OR     = 10'd444;
    localparam logic [9:0] XO_NAND   = 10'd476;
    localparam logic [9:0] XO_EXTSB  = 10'd954;
    localparam logic [9:0] XO_EXTSH  = 10'd922;
    localparam logic [9:0] XO_CNTLZW = 10'd26;
    localparam logic [9:0] XO_SLW    = 10'd24;
    localparam logic [9:0] XO_SRAWI  = 10'd824;

    // Extended opcodes (9-bit, XO form with OE)
    localparam logic [8:0] XO9_ADD   = 9'd266;
    localparam logic [8:0] XO9_SUBF  = 9'd40;
    localparam logic [8:0] XO9_NEG   = 9'd104;
    localparam logic [8:0] XO9_ADDC  = 9'd10;
    localparam logic [8:0] XO9_ADDZE = 9'd202;
    localparam logic [8:0] XO9_MULLW = 9'd235;

    // Condition field codes
    localparam logic [2:0] CR_LT = 3'd4;
    localparam logic [2:0] CR_GT = 3'd2;
    localparam logic [2:0] CR_EQ = 3'd1;

    // Operands fed to the execute logic
    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vs;
        logic        carry;
    } alu_in_t;

    // Effects of one instruction
    typedef struct packed {
        logic [31:0] res;
        logic        wr;
        logic [4:0]  tgt;
        logic        carry_we;
        logic        carry_val;
        logic        crw;
        logic [2:0]  crf;
        logic [2:0]  crb;
        logic        uns;
    } alu_out_t;

endpackage

FILE: sv/ppcx_alu.sv
// Combinational execute logic: decode and compute one integer instruction.
// Depends on ppcx_pkg for opcode codes and the operand/result structs.
module ppcx_alu
(
    input  ppcx_pkg::alu_in_t  op_in,
    output ppcx_pkg::alu_out_t op_out
);

    // Compare two words, signed or unsigned
    function automatic logic [2:0] cmp3(input logic [31:0] a, input logic [31:0] b,
                                        input logic sgn);
        logic [31:0] ax;
        logic [31:0] bx;
        begin
            ax = sgn ? (a ^ 32'h8000_0000) : a;
            bx = sgn ? (b ^ 32'h8000_0000) : b;
            if (ax < bx)
                cmp3 = ppcx_pkg::CR_LT;
            else if (ax > bx)
                cmp3 = ppcx_pkg::CR_GT;
            else
                cmp3 = ppcx_pkg::CR_EQ;
        end
    endfunction

    // Leading zeros of one byte, 8 when zero
    function automatic logic [3:0] lz8(input logic [7:0] v);
        logic [3:0] n;
        logic       found;
        begin
            n = 4'd0;
            found = 1'b0;
            for (int i = 7; i >= 0; i--)
            begin
                if (!found && v[i])
                    found = 1'b1;
                else if (!found)
                    n = n + 4'd1;
            end
            lz8 = n;
        end
    endfunction

    // Leading zeros of a word, composed from byte counts
    function automatic logic [5:0] lz32(input logic [31:0] v);
        logic [5:0] n;
        begin
            if (v[31:24] != 8'd0)
                n = {2'b00, lz8(v[31:24])};
            else if (v[23:16] != 8'd0)
                n = 6'd8 + {2'b00, lz8(v[23:16])};
            else if (v[15:8] != 8'd0)
                n = 6'd16 + {2'b00, lz8(v[15:8])};
            else
                n = 6'd24 + {2'b00, lz8(v[7:0])};
            lz32 = n;
        end
    endfunction

    logic [5:0]  opc;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  sh;
    logic [4:0]  mb;
    logic [4:0]  me;
    logic        rc;
    logic        oe;
    logic [9:0]  x10;
    logic [8:0]  x9;
    logic [31:0] uimm;
    logic [31:0] uimm_hi;
    logic [31:0] simm;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vs;
    logic [31:0] rot;
    logic [63:0] rot_wide;
    logic [31:0] mask_hi;
    logic [31:0] mask_lo;
    logic [31:0] mask;
    logic [31:0] mul_b;
    logic [31:0] mul_lo;
    logic [63:0] mul_full;
    logic [32:0] add_imm;
    logic [32:0] add_rr;
    logic [32:0] add_ze;
    logic [31:0] sra_res;
    logic [31:0] sra_low;
    logic        rc0;
    ppcx_pkg::alu_out_t o;

    // Field extraction
    assign opc     = op_in.instr[31:26];
    assign rd      = op_in.instr[25:21];
    assign ra      = op_in.instr[20:16];
    assign sh      = op_in.instr[15:11];
    assign mb      = op_in.instr[10:6];
    assign me      = op_in.instr[5:1];
    assign rc      = op_in.instr[0];
    assign oe      = op_in.instr[10];
    assign x10     = op_in.instr[10:1];
    assign x9      = op_in.instr[9:1];
    assign uimm    = {16'h0000, op_in.instr[15:0]};
    assign uimm_hi = {op_in.instr[15:0], 16'h0000};
    assign simm    = {{16{op_in.instr[15]}}, op_in.instr[15:0]};
    assign va      = op_in.va;
    assign vb      = op_in.vb;
    assign vs      = op_in.vs;

    // Rotate and mask
    assign rot_wide = {vs, vs} << sh;
    assign rot      = rot_wide[63:32];
    assign mask_hi  = 32'hFFFF_FFFF >> mb;
    assign mask_lo  = 32'hFFFF_FFFF << (5'd31 - me);
    assign mask     = (mb <= me) ? (mask_hi & mask_lo) : (mask_hi | mask_lo);

    // One shared multiplier for mulli and mullw
    assign mul_b    = (opc == ppcx_pkg::OP_MULLI) ? simm : vb;
    assign mul_full = va * mul_b;
    assign mul_lo   = mul_full[31:0];

    // Adders with carry out
    assign add_imm = {1'b0, va} + {1'b0, simm};
    assign add_rr  = {1'b0, va} + {1'b0, vb};
    assign add_ze  = {1'b0, va} + {32'd0, op_in.carry};

    // Arithmetic shift right by immediate
    assign sra_res = $unsigned($signed(vs) >>> sh);
    assign sra_low = vs & ~(32'hFFFF_FFFF << sh);

    // Decode and select
    always_comb
    begin
        o = '0;
        o.wr = 1'b1;
        o.tgt = rd;
        rc0 = 1'b0;
        unique case (opc)
            ppcx_pkg::OP_MULLI: o.res = mul_lo;
            ppcx_pkg::OP_CMPLI:
            begin
                o.wr = 1'b0; o.crw = 1'b1; o.crf = rd[4:2];
                o.crb = cmp3(va, uimm, 1'b0);
            end
            ppcx_pkg::OP_CMPI:
            begin
                o.wr = 1'b0; o.crw = 1'b1; o.crf = rd[4:2];
                o.crb = cmp3(va, simm, 1'b1);
            end
            ppcx_pkg::OP_ADDIC, ppcx_pkg::OP_ADDICR:
            begin
                o.res = add_imm[31:0];
                o.carry_we = 1'b1; o.carry_val = add_imm[32];
                rc0 = (opc == ppcx_pkg::OP_ADDICR);
            end
            ppcx_pkg::OP_ADDI:  o.res = ((ra != 5'd0) ? va : 32'd0) + simm;
            ppcx_pkg::OP_ADDIS: o.res = ((ra != 5'd0) ? va : 32'd0) + uimm_hi;
            ppcx_pkg::OP_RLWIMI:
            begin
                o.res = (va & ~mask) | (rot & mask);
                o.tgt = ra; rc0 = rc;
            end
            ppcx_pkg::OP_RLWINM:
            begin
                o.res = rot & mask;
                o.tgt = ra; rc0 = rc;
            end
            ppcx_pkg::OP_ORI:   begin o.res = vs | uimm;    o.tgt = ra; end
            ppcx_pkg::OP_ORIS:  begin o.res = vs | uimm_hi; o.tgt = ra; end
            ppcx_pkg::OP_XORI:  begin o.res = vs ^ uimm;    o.tgt = ra; end
            ppcx_pkg::OP_XORIS: begin o.res = vs ^ uimm_hi; o.tgt = ra; end
            ppcx_pkg::OP_ANDI:  begin o.res = vs & uimm;    o.tgt = ra; rc0 = 1'b1; end
            ppcx_pkg::OP_ANDIS: begin o.res = vs & uimm_hi; o.tgt = ra; rc0 = 1'b1; end
            ppcx_pkg::OP_EXT:
            begin
                o.tgt = ra;
                rc0 = rc;
                unique case (x10)
                    ppcx_pkg::XO_CMP:
                    begin
                        o.wr = 1'b0; rc0 = 1'b0; o.crw = 1'b1; o.crf = rd[4:2];
                        o.crb = cmp3(va, vb, 1'b1);
                    end
                    ppcx_pkg::XO_CMPL:
                    begin
                        o.wr = 1'b0; rc0 = 1'b0; o.crw = 1'b1; o.crf = rd[4:2];
                        o.crb = cmp3(va, vb, 1'b0);
                    end
                    ppcx_pkg::XO_AND:    o.res = vs & vb;
                    ppcx_pkg::XO_ANDC:   o.res = vs & ~vb;
                    ppcx_pkg::XO_NOR:    o.res = ~(vs | vb);
                    ppcx_pkg::XO_EQV:    o.res = ~(vs ^ vb);
                    ppcx_pkg::XO_XOR:    o.res = vs ^ vb;
                    ppcx_pkg::XO_ORC:    o.res = vs | ~vb;
                    ppcx_pkg::XO_OR:     o.res = vs | vb;
                    ppcx_pkg::XO_NAND:   o.res = ~(vs & vb);
                    ppcx_pkg::XO_EXTSB:  o.res = {{24{vs[7]}}, vs[7:0]};
                    ppcx_pkg::XO_EXTSH:  o.res = {{16{vs[15]}}, vs[15:0]};
                    ppcx_pkg::XO_CNTLZW: o.res = (vs == 32'd0) ? 32'd32 : {26'd0, lz32(vs)};
                    ppcx_pkg::XO_SLW:    o.res = vb[5] ? 32'd0 : (vs << vb[4:0]);
                    ppcx_pkg::XO_SRAWI:
                    begin
                        o.carry_we = 1'b1;
                        if (sh == 5'd0)
                        begin
                            o.res = vs;
                            o.carry_val = 1'b0;
                        end
                        else
                        begin
                            o.res = sra_res;
                            o.carry_val = vs[31] && (sra_low != 32'd0);
                        end
                    end
                    default:
                    begin
                        o.tgt = rd;
                        if (x9 != ppcx_pkg::XO9_ADD && x9 != ppcx_pkg::XO9_SUBF &&
                            x9 != ppcx_pkg::XO9_NEG && x9 != ppcx_pkg::XO9_ADDC &&
                            x9 != ppcx_pkg::XO9_ADDZE && x9 != ppcx_pkg::XO9_MULLW)
                            o.uns = 1'b1;
                        else if (oe)
                            o.uns = 1'b1;
                        else if (x9 == ppcx_pkg::XO9_ADD)
                            o.res = add_rr[31:0];
                        else if (x9 == ppcx_pkg::XO9_SUBF)
                            o.res = vb - va;
                        else if (x9 == ppcx_pkg::XO9_NEG)
                            o.res = 32'd0 - va;
                        else if (x9 == ppcx_pkg::XO9_ADDC)
                        begin
                            o.res = add_rr[31:0];
                            o.carry_we = 1'b1; o.carry_val = add_rr[32];
                        end
                        else if (x9 == ppcx_pkg::XO9_ADDZE)
                        begin
                            o.res = add_ze[31:0];
                            o.carry_we = 1'b1; o.carry_val = add_ze[32];
                        end
                        else
                            o.res = mul_lo;
                    end
                endcase
            end
            default: o.uns = 1'b1;
        endcase

        // Record field 0 for Rc forms
        if (rc0)
        begin
            o.crw = 1'b1;
            o.crf = 3'd0;
            o.crb = cmp3(o.res, 32'd0, 1'b1);
        end

        // Drop all effects of an unhandled instruction
        if (o.uns)
        begin
            o.res = '0; o.wr = 1'b0; o.carry_we = 1'b0;
            o.crw = 1'b0; o.crf = '0; o.crb = '0;
        end
        op_out = o;
    end

endmodule

FILE: sv/powerpc_integer_execute_unit.sv
// PowerPC 32-bit integer execute unit. Takes one transaction per cycle while in_stall is low
// and returns one result per transaction: the register file is read at the accept edge
// (synchronous read), the instruction executes in the next cycle and commits its register,
// carry and condition effects as it moves into the output register. A write committed at
// the same edge as a following read is forwarded. The register file reads as zero after
// reset through per-entry valid bits; no clearing pass is needed. Depends on ppcx_pkg and
// ppcx_alu.
module powerpc_integer_execute_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] instr_word,
    input  logic [4:0]  reg_index,
    input  logic [31:0] write_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_value,
    output logic [4:0]  dest_index,
    output logic        dest_written,
    output logic        carry_out,
    output logic [2:0]  cr_field,
    output logic [2:0]  cr_bits,
    output logic        cr_written,
    output logic        unsupported
);

    // Two copies of the register file: A serves rA and rB, B serves rS and reads
    logic [31:0] mem_a [ppcx_pkg::NREG];
    logic [31:0] mem_b [ppcx_pkg::NREG];
    logic [ppcx_pkg::NREG-1:0] rf_vld_reg;

    logic        in_acc;
    logic        s1_adv;
    logic        s1_valid_reg;
    logic [1:0]  s1_cmd_reg;
    logic [31:0] s1_instr_reg;
    logic [4:0]  s1_idx_reg;
    logic [31:0] s1_wval_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic [31:0] rd_s_reg;
    logic        vld_a_reg;
    logic        vld_b_reg;
    logic        vld_s_reg;
    logic        hit_a_reg;
    logic        hit_b_reg;
    logic        hit_s_reg;
    logic [31:0] byp_data_reg;
    logic        carry_reg;
    logic        carry_next;

    logic [4:0]  addr_a;
    logic [4:0]  addr_b;
    logic [4:0]  addr_s;
    logic        mem_we;
    logic [4:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] op_s;

    logic [31:0] res_next;
    logic [4:0]  dst_next;
    logic        dw_next;
    logic [2:0]  crf_next;
    logic [2:0]  crb_next;
    logic        crw_next;
    logic        uns_next;

    ppcx_pkg::alu_in_t  alu_in;
    ppcx_pkg::alu_out_t alu_out;

    // Handshake: execute stage drains into the output register
    assign s1_adv   = s1_valid_reg && (!out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;

    // Read addresses come straight from the incoming transaction
    assign addr_a = instr_word[20:16];
    assign addr_b = instr_word[15:11];
    assign addr_s = (command == ppcx_pkg::CMD_READ) ? reg_index : instr_word[25:21];

    // Register file write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_a[mem_waddr] <= mem_wdata;
            mem_b[mem_waddr] <= mem_wdata;
        end
    end

    // Register file read ports
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_a_reg <= mem_a[addr_a];
            rd_b_reg <= mem_a[addr_b];
            rd_s_reg <= mem_b[addr_s];
        end
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rf_vld_reg <= '0;
        else if (mem_we)
            rf_vld_reg[mem_waddr] <= 1'b1;
    end

    // Capture payload, valid flags and a same-edge write for forwarding
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg   <= command;
            s1_instr_reg <= instr_word;
            s1_idx_reg   <= reg_index;
            s1_wval_reg  <= write_value;
            vld_a_reg    <= rf_vld_reg[addr_a];
            vld_b_reg    <= rf_vld_reg[addr_b];
            vld_s_reg    <= rf_vld_reg[addr_s];
            hit_a_reg    <= mem_we && (mem_waddr == addr_a);
            hit_b_reg    <= mem_we && (mem_waddr == addr_b);
            hit_s_reg    <= mem_we && (mem_waddr == addr_s);
            byp_data_reg <= mem_wdata;
        end
    end

    // Execute stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // Operand select: forward, stored value, or zero
    assign op_a = hit_a_reg ? byp_data_reg : (vld_a_reg ? rd_a_reg : 32'd0);
    assign op_b = hit_b_reg ? byp_data_reg : (vld_b_reg ? rd_b_reg : 32'd0);
    assign op_s = hit_s_reg ? byp_data_reg : (vld_s_reg ? rd_s_reg : 32'd0);

    assign alu_in.instr = s1_instr_reg;
    assign alu_in.va    = op_a;
    assign alu_in.vb    = op_b;
    assign alu_in.vs    = op_s;
    assign alu_in.carry = carry_reg;

    ppcx_alu u_alu
    (
        .op_in  (alu_in),
        .op_out (alu_out)
    );

    // Command dispatch
    always_comb
    begin
        res_next   = '0;
        dst_next   = '0;
        dw_next    = 1'b0;
        crf_next   = '0;
        crb_next   = '0;
        crw_next   = 1'b0;
        uns_next   = 1'b0;
        carry_next = carry_reg;
        unique case (s1_cmd_reg)
            ppcx_pkg::CMD_WRITE:
            begin
                res_next = s1_wval_reg;
                dst_next = s1_idx_reg;
                dw_next  = 1'b1;
            end
            ppcx_pkg::CMD_READ:
            begin
                res_next = op_s;
                dst_next = s1_idx_reg;
            end
            ppcx_pkg::CMD_NONE: uns_next = 1'b1;
            ppcx_pkg::CMD_EXEC:
            begin
                res_next = alu_out.res;
                dst_next = alu_out.wr ? alu_out.tgt : 5'd0;
                dw_next  = alu_out.wr;
                crf_next = alu_out.crf;
                crb_next = alu_out.crb;
                crw_next = alu_out.crw;
                uns_next = alu_out.uns;
                if (alu_out.carry_we)
                    carry_next = alu_out.carry_val;
            end
            default: uns_next = 1'b1;
        endcase
    end

    // Commit register write as the result leaves the execute stage
    assign mem_we    = s1_adv && dw_next;
    assign mem_waddr = dst_next;
    assign mem_wdata = res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carry_reg <= 1'b0;
        else if (s1_adv)
            carry_reg <= carry_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (s1_adv)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            result_value <= res_next;
            dest_index   <= dst_next;
            dest_written <= dw_next;
            carry_out    <= carry_next;
            cr_field     <= crf_next;
            cr_bits      <= crb_next;
            cr_written   <= crw_next;
            unsupported  <= uns_next;
        end
    end

    // Checks
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty execute stage");

    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (s1_valid_reg && s1_adv))
        else $error("register file written without a committing transaction");

    a_commit_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid)
        else $error("committed result did not reach the output register");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for powerpc_integer_execute_unit.
// Depends on ppcx_pkg; drives random PowerPC integer instructions and register commands.
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] iw;
        logic [4:0]  ri;
        logic [31:0] wv;
    } xact_t;

    typedef struct packed {
        logic [31:0] res;
        logic [4:0]  dst;
        logic        dw;
        logic        cy;
        logic [2:0]  crf;
        logic [2:0]  crb;
        logic        crw;
        logic        uns;
    } outcome_t;

    localparam int WATCHDOG_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] command;
    logic [31:0] instr_word;
    logic [4:0] reg_index;
    logic [31:0] write_value;
    logic out_valid;
    logic out_stall;
    logic [31:0] result_value;
    logic [4:0] dest_index;
    logic dest_written;
    logic carry_out;
    logic [2:0] cr_field;
    logic [2:0] cr_bits;
    logic cr_written;
    logic unsupported;

    xact_t    pending_q[$];
    outcome_t expected_q[$];
    int       error_count;
    int       idle_cycles;
    int       in_gap;
    int       out_gap;
    bit       stim_done;

    // Shadow architectural state
    logic [31:0] gpr[32];
    logic        xer_ca;
    logic [2:0]  crf_shadow[8];

    powerpc_integer_execute_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .instr_word(instr_word),
        .reg_index(reg_index), .write_value(write_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_value(result_value), .dest_index(dest_index),
        .dest_written(dest_written), .carry_out(carry_out),
        .cr_field(cr_field), .cr_bits(cr_bits),
        .cr_written(cr_written), .unsupported(unsupported)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [2:0] cmp_u(logic [31:0] a, logic [31:0] b);
        if (a < b) return ppcx_pkg::CR_LT;
        if (a > b) return ppcx_pkg::CR_GT;
        return ppcx_pkg::CR_EQ;
    endfunction

    function automatic logic [2:0] cmp_s(logic [31:0] a, logic [31:0] b);
        return cmp_u(a ^ 32'h8000_0000, b ^ 32'h8000_0000);
    endfunction

    function automatic logic [31:0] rotl32(logic [31:0] v, logic [4:0] n);
        return (n == 5'd0) ? v : ((v << n) | (v >> (6'd32 - {1'b0, n})));
    endfunction

    function automatic logic [31:0] rlw_mask(logic [4:0] mb, logic [4:0] me);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = 32'hFFFF_FFFF >> mb;
        lo = 32'hFFFF_FFFF << (5'd31 - me);
        return (mb <= me) ? (hi & lo) : (hi | lo);
    endfunction

    function automatic logic [31:0] lead_zeros(logic [31:0] v);
        for (int i = 31; i >= 0; i--)
            if (v[i]) return 32'(31 - i);
        return 32'd32;
    endfunction

    // Execute one transaction against the shadow state and return its outcome
    function automatic outcome_t execute_xact(xact_t t);
        outcome_t o;
        logic [5:0] op;
        logic [4:0] rd, ra, rb;
        logic [9:0] x10;
        logic [8:0] x9;
        logic [31:0] va, vb, vs, simm, uimm, m, res;
        logic [4:0] tgt;
        logic wr, rc0;
        o = '0;
        if (t.cmd == ppcx_pkg::CMD_WRITE)
        begin
            gpr[t.ri] = t.wv;
            o.res = t.wv; o.dst = t.ri; o.dw = 1'b1;
        end
        else if (t.cmd == ppcx_pkg::CMD_READ)
        begin
            o.res = gpr[t.ri]; o.dst = t.ri;
        end
        else if (t.cmd == ppcx_pkg::CMD_NONE)
        begin
            o.uns = 1'b1;
        end
        else
        begin
            op = t.iw[31:26]; rd = t.iw[25:21]; ra = t.iw[20:16]; rb = t.iw[15:11];
            x10 = t.iw[10:1]; x9 = t.iw[9:1];
            uimm = {16'h0, t.iw[15:0]};
            simm = {{16{t.iw[15]}}, t.iw[15:0]};
            va = gpr[ra]; vb = gpr[rb]; vs = gpr[rd];
            tgt = rd; wr = 1'b1; rc0 = 1'b0; res = '0;
            case (op)
                ppcx_pkg::OP_MULLI: res = va * simm;
                ppcx_pkg::OP_CMPLI:
                begin
                    wr = 1'b0; o.crf = rd[4:2]; o.crb = cmp_u(va, uimm); o.crw = 1'b1;
                end
                ppcx_pkg::OP_CMPI:
                begin
                    wr = 1'b0; o.crf = rd[4:2]; o.crb = cmp_s(va, simm); o.crw = 1'b1;
                end
                ppcx_pkg::OP_ADDIC, ppcx_pkg::OP_ADDICR:
                begin
                    res = va + simm; xer_ca = res < va;
                    rc0 = (op == ppcx_pkg::OP_ADDICR);
                end
                ppcx_pkg::OP_ADDI:  res = (ra != 5'd0 ? va : 32'h0) + simm;
                ppcx_pkg::OP_ADDIS: res = (ra != 5'd0 ? va : 32'h0) + (uimm << 16);
                ppcx_pkg::OP_RLWIMI:
                begin
                    m = rlw_mask(t.iw[10:6], t.iw[5:1]);
                    res = (va & ~m) | (rotl32(vs, rb) & m); tgt = ra; rc0 = t.iw[0];
                end
                ppcx_pkg::OP_RLWINM:
                begin
                    res = rotl32(vs, rb) & rlw_mask(t.iw[10:6], t.iw[5:1]);
                    tgt = ra; rc0 = t.iw[0];
                end
                ppcx_pkg::OP_ORI:   begin res = vs | uimm; tgt = ra; end
                ppcx_pkg::OP_ORIS:  begin res = vs | (uimm << 16); tgt = ra; end
                ppcx_pkg::OP_XORI:  begin res = vs ^ uimm; tgt = ra; end
                ppcx_pkg::OP_XORIS: begin res = vs ^ (uimm << 16); tgt = ra; end
                ppcx_pkg::OP_ANDI:  begin res = vs & uimm; tgt = ra; rc0 = 1'b1; end
                ppcx_pkg::OP_ANDIS: begin res = vs & (uimm << 16); tgt = ra; rc0 = 1'b1; end
                ppcx_pkg::OP_EXT:
                begin
                    tgt = ra; rc0 = t.iw[0];
                    case (x10)
                        ppcx_pkg::XO_CMP:
                        begin
                            wr = 1'b0; rc0 = 1'b0; o.crf = rd[4:2];
                            o.crb = cmp_s(va, vb); o.crw = 1'b1;
                        end
                        ppcx_pkg::XO_CMPL:
                        begin
                            wr = 1'b0; rc0 = 1'b0; o.crf = rd[4:2];
                            o.crb = cmp_u(va, vb); o.crw = 1'b1;
                        end
                        ppcx_pkg::XO_AND:    res = vs & vb;
                        ppcx_pkg::XO_ANDC:   res = vs & ~vb;
                        ppcx_pkg::XO_NOR:    res = ~(vs | vb);
                        ppcx_pkg::XO_EQV:    res = ~(vs ^ vb);
                        ppcx_pkg::XO_XOR:    res = vs ^ vb;
                        ppcx_pkg::XO_ORC:    res = vs | ~vb;
                        ppcx_pkg::XO_OR:     res = vs | vb;
                        ppcx_pkg::XO_NAND:   res = ~(vs & vb);
                        ppcx_pkg::XO_EXTSB:  res = {{24{vs[7]}}, vs[7:0]};
                        ppcx_pkg::XO_EXTSH:  res = {{16{vs[15]}}, vs[15:0]};
                        ppcx_pkg::XO_CNTLZW: res = lead_zeros(vs);
                        ppcx_pkg::XO_SLW:    res = vb[5] ? 32'h0 : (vs << vb[4:0]);
                        ppcx_pkg::XO_SRAWI:
                        begin
                            res = $unsigned($signed(vs) >>> rb);
                            xer_ca = vs[31] && ((vs & ((32'h1 << rb) - 32'h1)) != 32'h0);
                        end
                        default:
                        begin
                            tgt = rd;
                            if (!(x9 inside {ppcx_pkg::XO9_ADD, ppcx_pkg::XO9_SUBF,
                                             ppcx_pkg::XO9_NEG, ppcx_pkg::XO9_ADDC,
                                             ppcx_pkg::XO9_ADDZE, ppcx_pkg::XO9_MULLW})
                                || t.iw[10])
                                o.uns = 1'b1;
                            else if (x9 == ppcx_pkg::XO9_ADD)  res = va + vb;
                            else if (x9 == ppcx_pkg::XO9_SUBF) res = vb - va;
                            else if (x9 == ppcx_pkg::XO9_NEG)  res = 32'h0 - va;
                            else if (x9 == ppcx_pkg::XO9_ADDC)
                            begin
                                res = va + vb; xer_ca = res < va;
                            end
                            else if (x9 == ppcx_pkg::XO9_ADDZE)
                            begin
                                res = va + {31'd0, xer_ca}; xer_ca = res < va;
                            end
                            else res = va * vb;
                        end
                    endcase
                end
                default: o.uns = 1'b1;
            endcase
            if (o.uns)
            begin
                o.crf = 3'd0; o.crb = 3'd0; o.crw = 1'b0;
            end
            else
            begin
                if (wr)
                begin
                    gpr[tgt] = res; o.dst = tgt; o.dw = 1'b1;
                end
                if (rc0)
                begin
                    o.crf = 3'd0; o.crb = cmp_s(res, 32'h0); o.crw = 1'b1;
                end
                if (o.crw) crf_shadow[o.crf] = o.crb;
                o.res = res;
            end
        end
        o.cy = xer_ca;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [5:0] ops[16];
        logic [9:0] xos[15];
        logic [8:0] xo9s[6];
        logic [31:0] w;
        ops = '{ppcx_pkg::OP_MULLI, ppcx_pkg::OP_CMPLI, ppcx_pkg::OP_CMPI,
                ppcx_pkg::OP_ADDIC, ppcx_pkg::OP_ADDICR, ppcx_pkg::OP_ADDI,
                ppcx_pkg::OP_ADDIS, ppcx_pkg::OP_RLWIMI, ppcx_pkg::OP_RLWINM,
                ppcx_pkg::OP_ORI, ppcx_pkg::OP_ORIS, ppcx_pkg::OP_XORI,
                ppcx_pkg::OP_XORIS, ppcx_pkg::OP_ANDI, ppcx_pkg::OP_ANDIS,
                ppcx_pkg::OP_EXT};
        xos = '{ppcx_pkg::XO_CMP, ppcx_pkg::XO_CMPL, ppcx_pkg::XO_AND,
                ppcx_pkg::XO_ANDC, ppcx_pkg::XO_NOR, ppcx_pkg::XO_EQV,
                ppcx_pkg::XO_XOR, ppcx_pkg::XO_ORC, ppcx_pkg::XO_OR,
                ppcx_pkg::XO_NAND, ppcx_pkg::XO_EXTSB, ppcx_pkg::XO_EXTSH,
                ppcx_pkg::XO_CNTLZW, ppcx_pkg::XO_SLW, ppcx_pkg::XO_SRAWI};
        xo9s = '{ppcx_pkg::XO9_ADD, ppcx_pkg::XO9_SUBF, ppcx_pkg::XO9_NEG,
                 ppcx_pkg::XO9_ADDC, ppcx_pkg::XO9_ADDZE, ppcx_pkg::XO9_MULLW};
        w = $urandom();
        case ($urandom_range(0, 9))
            0: ;
            1, 2, 3: w[31:26] = ops[$urandom_range(0, 15)];
            4, 5, 6:
            begin
                w[31:26] = ppcx_pkg::OP_EXT; w[10:1] = xos[$urandom_range(0, 14)];
            end
            default:
            begin
                w[31:26] = ppcx_pkg::OP_EXT; w[9:1] = xo9s[$urandom_range(0, 5)];
                w[10] = ($urandom_range(0, 7) == 0);
            end
        endcase
        return w;
    endfunction

    function automatic xact_t mk(logic [1:0] c, logic [31:0] iw, logic [4:0] ri,
                                 logic [31:0] wv);
        xact_t t;
        t.cmd = c; t.iw = iw; t.ri = ri; t.wv = wv;
        return t;
    endfunction

    // Queue an execute transaction
    function automatic void push_exec(logic [31:0] iw);
        pending_q.push_back(mk(ppcx_pkg::CMD_EXEC, iw, 5'd0, 32'd0));
    endfunction

    // Fill the pending queue: directed corner cases first, then random traffic
    initial
    begin
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        for (int i = 0; i < 8; i++) crf_shadow[i] = '0;
        xer_ca = 1'b0;
        pending_q.push_back(mk(ppcx_pkg::CMD_READ, 32'h0, 5'd31, 32'h0));
        pending_q.push_back(mk(ppcx_pkg::CMD_WRITE, 32'hFFFF_FFFF, 5'd1, 32'hFFFF_FFFF));
        pending_q.push_back(mk(ppcx_pkg::CMD_WRITE, 32'h0, 5'd2, 32'h8000_0000));
        pending_q.push_back(mk(ppcx_pkg::CMD_WRITE, 32'h0, 5'd0, 32'h0000_0001));
        pending_q.push_back(mk(ppcx_pkg::CMD_NONE, $urandom(), 5'd3, 32'h1234_5678));
        // addi with r0 base, addis, addic overflow, addze carry, cntlzw of zero
        push_exec({ppcx_pkg::OP_ADDI, 5'd3, 5'd0, 16'h8000});
        push_exec({ppcx_pkg::OP_ADDIS, 5'd4, 5'd0, 16'hFFFF});
        push_exec({ppcx_pkg::OP_ADDICR, 5'd5, 5'd1, 16'h0001});
        push_exec({ppcx_pkg::OP_EXT, 5'd6, 5'd1, 5'd0, 1'b0, ppcx_pkg::XO9_ADDZE, 1'b1});
        push_exec({ppcx_pkg::OP_EXT, 5'd7, 5'd8, 5'd0, ppcx_pkg::XO_CNTLZW, 1'b1});
        // srawi. on negative source with bits shifted out, and shift by zero
        push_exec({ppcx_pkg::OP_EXT, 5'd1, 5'd9, 5'd4, ppcx_pkg::XO_SRAWI, 1'b1});
        push_exec({ppcx_pkg::OP_EXT, 5'd2, 5'd10, 5'd0, ppcx_pkg::XO_SRAWI, 1'b0});
        // slw with a zero shift amount, an OE form, compares
        push_exec({ppcx_pkg::OP_EXT, 5'd1, 5'd11, 5'd2, ppcx_pkg::XO_SLW, 1'b0});
        push_exec({ppcx_pkg::OP_EXT, 5'd12, 5'd1, 5'd2, 1'b1, ppcx_pkg::XO9_ADD, 1'b0});
        push_exec({ppcx_pkg::OP_EXT, 5'd28, 5'd1, 5'd2, ppcx_pkg::XO_CMP, 1'b1});
        push_exec({ppcx_pkg::OP_EXT, 5'd31, 5'd1, 5'd2, ppcx_pkg::XO_CMPL, 1'b0});
        push_exec({ppcx_pkg::OP_CMPI, 5'd8, 5'd2, 16'h7FFF});
        push_exec({ppcx_pkg::OP_CMPLI, 5'd20, 5'd2, 16'hFFFF});
        push_exec({ppcx_pkg::OP_RLWIMI, 5'd1, 5'd2, 5'd31, 5'd31, 5'd0, 1'b1});
        push_exec({ppcx_pkg::OP_RLWINM, 5'd1, 5'd13, 5'd1, 5'd0, 5'd31, 1'b1});
        push_exec(32'hFFFF_FFFF);
        push_exec(32'h0);
        for (int n = 0; n < 850; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                pending_q.push_back(mk(ppcx_pkg::CMD_WRITE, $urandom(), 5'($urandom()),
                                       rand_word()));
            else if ($urandom_range(0, 9) == 0)
                pending_q.push_back(mk(2'($urandom_range(2, 3)), $urandom(),
                                       5'($urandom()), $urandom()));
            else
                pending_q.push_back(mk(ppcx_pkg::CMD_EXEC, rand_instr(), 5'($urandom()),
                                       $urandom()));
        end
    end

    // Reset
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: present pending transactions with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0; instr_word <= '0; reg_index <= '0; write_value <= '0;
            in_gap <= 0;
            stim_done <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(execute_xact(pending_q.pop_front()));
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    command <= pending_q[0].cmd;
                    instr_word <= pending_q[0].iw;
                    reg_index <= pending_q[0].ri;
                    write_value <= pending_q[0].wv;
                    in_gap <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: stall at random and check each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
            error_count <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                idle_cycles <= 0;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, result_value);
                    error_count <= error_count + 1;
                end
                else
                begin
                    automatic outcome_t e = expected_q.pop_front();
                    automatic outcome_t a = {result_value, dest_index, dest_written,
                                             carry_out, cr_field, cr_bits, cr_written,
                                             unsupported};
                    if (a !== e)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, a);
                        error_count <= error_count + 1;
                    end
                end
            end
            else if (in_valid && !in_stall)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // End of run: drain, settle, report
    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && expected_q.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
        end
        else if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
